### sv/vupd_pkg.sv
// Shared types and constants for the vertex/uv pair deduplication block.
`default_nettype none

package vupd_pkg;

   // Fixed field widths of the item channels
   localparam int unsigned FIELD_WIDTH       = 16;
   localparam int unsigned FINAL_INDEX_WIDTH = 10;

   // One input item: a triangle corner
   typedef struct packed {
      logic                   restart;
      logic [FIELD_WIDTH-1:0] vertex_index;
      logic [FIELD_WIDTH-1:0] uv_index;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic [FINAL_INDEX_WIDTH-1:0] final_index;
      logic                         was_inserted;
      logic                         table_full;
   } rsp_item_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture the item, empty the table on restart
      logic scan;     // issue the next table read
      logic respond;  // finish the item: append on a miss with room, drive the result
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic hit;   // the entry just compared matches the key
      logic miss;  // every stored entry was compared without a match
   } status_type;

endpackage

`default_nettype wire

### sv/vupd_ctrl.sv
// Controller state machine that sequences the table search for each item.
`default_nettype none

module vupd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire vupd_pkg::status_type status,
   output vupd_pkg::cmd_type        cmd
);
   import vupd_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_SCAN = 1'b1;

   logic state_ff;
   logic state_in;
   logic done;

   assign done = status.hit | status.miss;

   // Next state: leave idle on an accepted item, return once the search ends
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               state_in = STATE_SCAN;
            end
         end
         STATE_SCAN: begin
            if (done) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive the datapath commands
   assign busy        = (state_ff == STATE_SCAN);
   assign cmd.load    = (state_ff == STATE_IDLE) & start;
   assign cmd.scan    = (state_ff == STATE_SCAN) & ~done;
   assign cmd.respond = (state_ff == STATE_SCAN) & done;

endmodule

`default_nettype wire

### sv/vupd_datapath.sv
// Datapath: pair table memory, search pointer, compare and result register.
`default_nettype none

module vupd_datapath #(
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned INDEX_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vupd_pkg::req_item_type req_item,
   input  wire vupd_pkg::cmd_type      cmd,
   output vupd_pkg::status_type       status,
   output logic                       rsp_valid,
   output vupd_pkg::rsp_item_type     rsp_item
);
   import vupd_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned PW = 2 * INDEX_WIDTH;

   // Pair table: {vertex, uv} in one word
   logic [PW-1:0] table_mem [TABLE_DEPTH];

   logic [PW-1:0] key_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] scan_ff;
   logic          rd_vld_ff;
   logic [AW-1:0] cmp_pos_ff;
   logic [PW-1:0] rd_data_ff;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;

   logic [PW-1:0] key_in;
   logic          issue;
   logic          room;

   assign key_in = {INDEX_WIDTH'(req_item.vertex_index), INDEX_WIDTH'(req_item.uv_index)};
   assign issue  = cmd.scan & (scan_ff != count_ff);
   assign room   = (count_ff != CW'(TABLE_DEPTH));

   // Search status
   assign status.hit  = rd_vld_ff & (rd_data_ff == key_ff);
   assign status.miss = ~rd_vld_ff & (scan_ff == count_ff);

   // Table memory: one registered read and one write port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= table_mem[scan_ff[AW-1:0]];
      end
      if (cmd.respond & ~status.hit & room) begin
         table_mem[count_ff[AW-1:0]] <= key_ff;
      end
   end

   // Capture the key and track the read in flight
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key_in;
      end
      if (issue) begin
         cmp_pos_ff <= scan_ff[AW-1:0];
      end
   end

   // Control registers: fill count, search pointer, read valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            scan_ff   <= '0;
            rd_vld_ff <= 1'b0;
            if (req_item.restart) begin
               count_ff <= '0;
            end
         end else if (cmd.scan) begin
            rd_vld_ff <= issue;
            if (issue) begin
               scan_ff <= scan_ff + CW'(1);
            end
         end else if (cmd.respond) begin
            rd_vld_ff <= 1'b0;
            if (~status.hit & room) begin
               count_ff <= count_ff + CW'(1);
            end
         end
      end
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   // Result payload: hit position, appended position, or full with index zero
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         if (status.hit) begin
            rsp_item_ff.final_index  <= FINAL_INDEX_WIDTH'(cmp_pos_ff);
            rsp_item_ff.was_inserted <= 1'b0;
            rsp_item_ff.table_full   <= 1'b0;
         end else if (room) begin
            rsp_item_ff.final_index  <= FINAL_INDEX_WIDTH'(count_ff);
            rsp_item_ff.was_inserted <= 1'b1;
            rsp_item_ff.table_full   <= 1'b0;
         end else begin
            rsp_item_ff.final_index  <= '0;
            rsp_item_ff.was_inserted <= 1'b0;
            rsp_item_ff.table_full   <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

### sv/vertex_uv_pair_dedup_core.sv
// A search ends at the first matching stored pair, or as a miss once all stored
// pairs were compared; an empty table misses without a read.
// One item is searched at a time; a new item is taken in the strobe cycle.
// The search compares one stored pair per cycle through the single read port
// of the pair table. Reset empties the table at once and clears the strobe.
// Top level of the vertex/uv pair deduplication block.
`default_nettype none

module vertex_uv_pair_dedup_core #(
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned INDEX_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire vupd_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   output vupd_pkg::rsp_item_type     rsp_item
);
   import vupd_pkg::*;

   cmd_type    cmd;
   status_type status;

   vupd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   vupd_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

### sv/vupd_checker.sv
// Port-level checker for the pair deduplication block and its bind.
`default_nettype none

module vupd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire vupd_pkg::req_item_type req_item,
   input wire logic                  rsp_valid,
   input wire vupd_pkg::rsp_item_type rsp_item
);
   import vupd_pkg::*;

   // An accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // A restart item always lands at position zero as a new entry
   a_restart_pos0: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.restart) |-> ##2
      (rsp_valid && rsp_item.was_inserted && rsp_item.final_index == '0))
      else $error("restart item not appended at position zero");

   // Insert and full never occur together; full reports index zero
   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.table_full) |->
      (!rsp_item.was_inserted && rsp_item.final_index == '0))
      else $error("full result with insert or nonzero index");

   // Strobes never come in consecutive cycles
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

endmodule

bind vertex_uv_pair_dedup_core vupd_checker u_vupd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

### tb/vertex_uv_pair_dedup_core_tb.sv
// Self-checking testbench for the vertex/uv pair deduplication core.
`timescale 1ns / 100ps

module vertex_uv_pair_dedup_core_tb;
   import vupd_pkg::*;

   localparam int unsigned TABLE_DEPTH   = 1024;
   localparam int unsigned RANDOM_ITEMS  = 580;
   localparam int unsigned IDLE_PERCENT  = 28;
   localparam int unsigned NO_IDLE_FIRST = 1150;
   localparam int unsigned NO_IDLE_LAST  = 1300;
   localparam int unsigned DRAIN_EVERY   = 150;
   localparam int unsigned MAX_REPORTS   = 10;

   logic         clock;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   // Corners waiting to be sent and lookup results waiting to arrive
   req_item_type corner_queue[$];
   rsp_item_type expected_lookups[$];

   // Shadow pair table used to predict each lookup
   logic [FIELD_WIDTH-1:0] stored_vertex[TABLE_DEPTH];
   logic [FIELD_WIDTH-1:0] stored_uv[TABLE_DEPTH];
   int unsigned            stored_count = 0;

   int unsigned accepted_count = 0;
   int unsigned received_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned hit_total      = 0;
   int unsigned insert_total   = 0;
   int unsigned full_total     = 0;
   int unsigned restart_total  = 0;
   longint      cycle_count    = 0;
   longint      cycle_limit    = 0;
   bit          drain_hold     = 1'b0;

   vertex_uv_pair_dedup_core #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .INDEX_WIDTH(FIELD_WIDTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Search the shadow table for one corner; append it on a miss with room
   function automatic rsp_item_type lookup_corner(req_item_type corner);
      rsp_item_type result;
      bit           found;
      result = '0;
      found  = 1'b0;
      if (corner.restart) begin
         stored_count = 0;
         restart_total++;
      end
      for (int i = 0; i < stored_count && !found; i++) begin
         if (stored_vertex[i] == corner.vertex_index && stored_uv[i] == corner.uv_index) begin
            found              = 1'b1;
            result.final_index = FINAL_INDEX_WIDTH'(i);
         end
      end
      if (found) begin
         hit_total++;
      end else if (stored_count < TABLE_DEPTH) begin
         stored_vertex[stored_count] = corner.vertex_index;
         stored_uv[stored_count]     = corner.uv_index;
         result.final_index          = FINAL_INDEX_WIDTH'(stored_count);
         result.was_inserted         = 1'b1;
         stored_count++;
         insert_total++;
      end else begin
         result.table_full = 1'b1;
         full_total++;
      end
      return result;
   endfunction

   task automatic queue_corner(input bit restart, input logic [FIELD_WIDTH-1:0] vtx,
                               input logic [FIELD_WIDTH-1:0] uv);
      req_item_type corner;
      corner.restart      = restart;
      corner.vertex_index = vtx;
      corner.uv_index     = uv;
      corner_queue.push_back(corner);
   endtask

   task automatic note_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH at cycle %0d: %s", cycle_count, detail);
   endtask

   // Present queued corners; hold each until accepted, idle at random outside a no-idle window, pause to drain
   always @(posedge clock) begin : drive_corners
      logic next_start;
      bit   allow_idle;
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_lookups.push_back(lookup_corner(req_item));
            void'(corner_queue.pop_front());
            accepted_count++;
            if (accepted_count % DRAIN_EVERY == DRAIN_EVERY / 2)
               drain_hold = 1'b1;
            next_start = 1'b0;
         end
         if (drain_hold && expected_lookups.size() == 0)
            drain_hold = 1'b0;
         allow_idle = !(accepted_count >= NO_IDLE_FIRST && accepted_count < NO_IDLE_LAST);
         if (!next_start && !drain_hold && corner_queue.size() != 0) begin
            if (!(allow_idle && $urandom_range(0, 99) < IDLE_PERCENT)) begin
               next_start = 1'b1;
               req_item   <= corner_queue[0];
            end
         end
         start <= next_start;
      end
   end

   // Compare each strobed result with the oldest awaited lookup
   always @(posedge clock) begin : check_lookups
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         received_count++;
         if (expected_lookups.size() == 0) begin
            note_mismatch($sformatf("result with nothing awaited: index %0d inserted %0b full %0b",
                                    rsp_item.final_index, rsp_item.was_inserted,
                                    rsp_item.table_full));
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_item.final_index !== want.final_index)
               note_mismatch($sformatf("final_index expected %0d got %0d",
                                       want.final_index, rsp_item.final_index));
            if (rsp_item.was_inserted !== want.was_inserted)
               note_mismatch($sformatf("was_inserted expected %0b got %0b",
                                       want.was_inserted, rsp_item.was_inserted));
            if (rsp_item.table_full !== want.table_full)
               note_mismatch($sformatf("table_full expected %0b got %0b",
                                       want.table_full, rsp_item.table_full));
         end
      end
   end

   // Abort on a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_limit != 0 && cycle_count > cycle_limit) begin
         $display("Timeout after %0d cycles, %0d results still awaited",
                  cycle_count, expected_lookups.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Build the stimulus, release reset, then wait for the block to drain
   initial begin : run_test
      logic [31:0]            fill_pairs[TABLE_DEPTH];
      logic [31:0]            shadow_pairs[$];
      logic [31:0]            pair;
      logic [FIELD_WIDTH-1:0] fill_base;
      int unsigned            made;
      int unsigned            seq_len;
      int unsigned            pick;
      int unsigned            slot;
      bit                     restart;

      // Directed corners: extremes, hits, near misses and restarts
      queue_corner(1'b0, 16'h0000, 16'h0000);
      queue_corner(1'b0, 16'h0000, 16'h0000);
      queue_corner(1'b0, 16'hFFFF, 16'hFFFF);
      queue_corner(1'b0, 16'h0000, 16'hFFFF);
      queue_corner(1'b0, 16'hFFFF, 16'h0000);
      queue_corner(1'b0, 16'hFFFF, 16'hFFFF);
      queue_corner(1'b0, 16'hFFFF, 16'h0000);
      queue_corner(1'b1, 16'hFFFF, 16'hFFFF);
      queue_corner(1'b0, 16'h0000, 16'h0000);
      queue_corner(1'b1, 16'hFFFF, 16'hFFFF);
      queue_corner(1'b0, 16'h8000, 16'h0001);
      queue_corner(1'b0, 16'h0001, 16'h8000);
      queue_corner(1'b0, 16'h8000, 16'h0001);
      queue_corner(1'b1, 16'hA5A5, 16'h5A5A);
      queue_corner(1'b0, 16'hA5A5, 16'h5A5A);

      // Fill the table with distinct vertices, then probe it while full
      fill_base = FIELD_WIDTH'($urandom);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         fill_pairs[k] = {fill_base ^ FIELD_WIDTH'(k), FIELD_WIDTH'($urandom)};
         queue_corner(k == 0, fill_pairs[k][31:16], fill_pairs[k][15:0]);
      end
      queue_corner(1'b0, fill_pairs[TABLE_DEPTH-1][31:16], fill_pairs[TABLE_DEPTH-1][15:0]);
      queue_corner(1'b0, fill_pairs[0][31:16], fill_pairs[0][15:0]);
      for (int k = 0; k < 30; k++) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, TABLE_DEPTH - 1);
         pair = fill_pairs[slot];
         if (pick < 15)
            pair[31:16] = fill_base ^ (16'h0400 | FIELD_WIDTH'($urandom));
         else if (pick < 30)
            pair[15:0] = pair[15:0] ^ FIELD_WIDTH'(1 << $urandom_range(0, 15));
         queue_corner(1'b0, pair[31:16], pair[15:0]);
      end
      queue_corner(1'b1, fill_pairs[7][31:16], fill_pairs[7][15:0]);
      queue_corner(1'b0, fill_pairs[8][31:16], fill_pairs[8][15:0]);

      // Random meshes: mostly restarted short runs with heavy pair reuse
      made = 0;
      while (made < RANDOM_ITEMS) begin
         seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
         for (int j = 0; j < seq_len && made < RANDOM_ITEMS; j++) begin
            if (j == 0)
               restart = ($urandom_range(0, 9) != 0) || shadow_pairs.size() > 500;
            else
               restart = ($urandom_range(0, 49) == 0);
            if (restart)
               shadow_pairs.delete();
            pick = $urandom_range(0, 99);
            if (shadow_pairs.size() != 0 && pick < 70) begin
               pair = shadow_pairs[$urandom_range(0, shadow_pairs.size() - 1)];
               if (pick >= 55) begin
                  // near miss: one bit off in one of the two indices
                  if ($urandom_range(0, 1))
                     pair[15:0] = pair[15:0] ^ FIELD_WIDTH'(1 << $urandom_range(0, 15));
                  else
                     pair[31:16] = pair[31:16] ^ FIELD_WIDTH'(1 << $urandom_range(0, 15));
               end
            end else begin
               pair = $urandom;
            end
            queue_corner(restart, pair[31:16], pair[15:0]);
            if (pick >= 55 || shadow_pairs.size() == 0)
               shadow_pairs.push_back(pair);
            made++;
         end
      end

      cycle_limit = 3 * longint'(corner_queue.size()) * (TABLE_DEPTH + 3 + 40) + 20000;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait until every corner was taken and every lookup came back
      while (corner_queue.size() != 0 || start)
         @(posedge clock);
      while (expected_lookups.size() != 0)
         @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      $display("Sent %0d corners, got %0d results: %0d hits, %0d inserts, %0d full-table misses,",
               accepted_count, received_count, hit_total, insert_total, full_total);
      $display("%0d restarts, including one fill to %0d entries; %0d mismatches",
               restart_total, TABLE_DEPTH, mismatch_count);
      if (mismatch_count == 0 && expected_lookups.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
